FILE: src/csr_sparse_matrix_vector_multiply_macros.svh
// assertion macros for the sparse matrix-vector multiply block
// used by files that check their own logic; no other dependencies
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CSR_SMV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csr_smv: implication check failed");

// condition must hold at every edge out of reset
`define CSR_SMV_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("csr_smv: invariant check failed");

`endif

FILE: src/csr_smv_pkg.sv
// shared types, sizes and codes of the sparse matrix-vector multiply block
// no dependencies
package csr_smv_pkg;

    // store sizes
    localparam int MAX_DIM = 64;
    localparam int MAX_NZ  = 4096;

    // derived widths
    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int DIM_CW = $clog2(MAX_DIM + 1);
    localparam int NZ_AW  = $clog2(MAX_NZ);
    localparam int NZ_CW  = $clog2(MAX_NZ + 1);
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 7;
    localparam int PAD_W  = 56 - (DIM_W + NZ_CW + VAL_W);

    // vector length counter saturates here
    localparam logic [CFG_W-1:0] VEC_SAT = {CFG_W{1'b1}};

    // register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_RPTR  = 2'd1,
        KIND_PROD  = 2'd2,
        KIND_ERR   = 2'd3
    } t_kind;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PTR,
        ST_PTR_WAIT,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // one result item
    typedef struct packed {
        t_kind              kind;
        logic [DIM_W-1:0]   index;
        logic [NZ_CW-1:0]   position;
        logic [VAL_W-1:0]   value;
        logic               last;
    } t_result;

    // control from the sequencer to the multiply-accumulate pipe
    typedef struct packed {
        logic issue;
        logic clear;
    } t_mac_ctl;

    // a zero register reads as one, above the store size as the store size
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            r = CFG_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

FILE: src/csr_smv_nz_mem.sv
// nonzero store: column and value of each stored nonzero
// one write port, one registered read port; uses csr_smv_pkg
module csr_smv_nz_mem (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [csr_smv_pkg::NZ_AW-1:0]        i_wr_addr,
    input  logic [csr_smv_pkg::DIM_W-1:0]        i_wr_col,
    input  logic [csr_smv_pkg::VAL_W-1:0]        i_wr_val,
    input  logic [csr_smv_pkg::NZ_AW-1:0]        i_rd_addr,
    output logic [csr_smv_pkg::DIM_W-1:0]        o_rd_col,
    output logic [csr_smv_pkg::VAL_W-1:0]        o_rd_val
);

    localparam int ENT_W = csr_smv_pkg::DIM_W + csr_smv_pkg::VAL_W;

    logic [ENT_W-1:0] mem [csr_smv_pkg::MAX_NZ];
    logic [ENT_W-1:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= {i_wr_col, i_wr_val};
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_col = r_rd[ENT_W-1:csr_smv_pkg::VAL_W];
    assign o_rd_val = r_rd[csr_smv_pkg::VAL_W-1:0];

endmodule

FILE: src/csr_smv_row_mem.sv
// per-row store: row end pointer of row r and vector element r share entry r
// one write port with a lane enable per field, one registered read port; uses csr_smv_pkg
module csr_smv_row_mem (
    input  logic                                 i_clk,
    input  logic [csr_smv_pkg::DIM_W-1:0]        i_wr_addr,
    input  logic                                 i_we_ptr,
    input  logic [csr_smv_pkg::NZ_CW-1:0]        i_wr_ptr,
    input  logic                                 i_we_vec,
    input  logic [csr_smv_pkg::VAL_W-1:0]        i_wr_vec,
    input  logic [csr_smv_pkg::DIM_W-1:0]        i_rd_addr,
    output logic [csr_smv_pkg::NZ_CW-1:0]        o_rd_ptr,
    output logic [csr_smv_pkg::VAL_W-1:0]        o_rd_vec
);

    logic [csr_smv_pkg::NZ_CW-1:0] mem_ptr [csr_smv_pkg::MAX_DIM];
    logic [csr_smv_pkg::VAL_W-1:0] mem_vec [csr_smv_pkg::MAX_DIM];

    // write lanes, one address
    always_ff @(posedge i_clk) begin
        if (i_we_ptr) begin
            mem_ptr[i_wr_addr] <= i_wr_ptr;
        end
        if (i_we_vec) begin
            mem_vec[i_wr_addr] <= i_wr_vec;
        end
    end

    // registered read of both lanes
    always_ff @(posedge i_clk) begin
        o_rd_ptr <= mem_ptr[i_rd_addr];
        o_rd_vec <= mem_vec[i_rd_addr];
    end

endmodule

FILE: src/csr_smv_mac.sv
// multiply-accumulate pipe: nonzero value, vector element, product, row sum
// follows the nonzero read issued by the sequencer; uses csr_smv_pkg
module csr_smv_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  csr_smv_pkg::t_mac_ctl                i_ctl,
    input  logic [csr_smv_pkg::VAL_W-1:0]        i_nz_val,
    input  logic [csr_smv_pkg::VAL_W-1:0]        i_vec_val,
    output logic                                 o_busy,
    output logic [csr_smv_pkg::VAL_W-1:0]        o_acc
);

    logic                           r_v1;
    logic                           r_v2;
    logic                           r_v3;
    logic [csr_smv_pkg::VAL_W-1:0]  r_b_val;
    logic [csr_smv_pkg::VAL_W-1:0]  r_prod;
    logic [csr_smv_pkg::VAL_W-1:0]  r_acc;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // hold the value while the vector element is read, then multiply (low 32 bits wrap)
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_b_val <= i_nz_val;
        end
        if (r_v2) begin
            r_prod <= i_vec_val * r_b_val;
        end
    end

    // row accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_busy = r_v1 | r_v2 | r_v3;
    assign o_acc  = r_acc;

endmodule

FILE: src/csr_sparse_matrix_vector_multiply.sv
// top level: stream ports, register port, load and multiply sequencer, output stage
// uses csr_smv_pkg, csr_smv_nz_mem, csr_smv_row_mem, csr_smv_mac and the macro header
//
// channel   direction  handshake                  payload
// s_axis    in         tvalid / tready            tdata value, tuser type, tlast last
// m_axis    out        tvalid / tready            tdata index/position/value, tuser kind,
//                                                 tlast last result
// apb       in         psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// matrix and vector elements are taken one per cycle unless held off; an element that yields
// both a column entry and a row pointer holds the input until the first result is taken
// the final vector element starts the multiply if the vector length fits the loaded matrix;
// it is paced by the single row store read port and the one-per-cycle nonzero store walk
// the input is held off during the multiply and while the output register is full
// reset is synchronous; the stores need no clearing pass, so items are taken right away
`include "csr_sparse_matrix_vector_multiply_macros.svh"

module csr_sparse_matrix_vector_multiply (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] elem_value
    input  logic [0:0]   s_axis_tuser,   // [0] req_type
    input  logic         s_axis_tlast,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,   // [5:0] index, [18:6] position, [50:19] value
    output logic [1:0]   m_axis_tuser,   // [1:0] kind
    output logic         m_axis_tlast,
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int DIM_W  = csr_smv_pkg::DIM_W;
    localparam int DIM_CW = csr_smv_pkg::DIM_CW;
    localparam int NZ_AW  = csr_smv_pkg::NZ_AW;
    localparam int NZ_CW  = csr_smv_pkg::NZ_CW;
    localparam int VAL_W  = csr_smv_pkg::VAL_W;
    localparam int CFG_W  = csr_smv_pkg::CFG_W;

    // registers
    csr_smv_pkg::t_state   r_state, n_state;
    logic [CFG_W-1:0]      r_num_rows, n_num_rows;
    logic [CFG_W-1:0]      r_num_cols, n_num_cols;
    logic [DIM_W-1:0]      r_cur_row, n_cur_row;
    logic [DIM_W-1:0]      r_cur_col, n_cur_col;
    logic [CFG_W-1:0]      r_vec_count, n_vec_count;
    logic                  r_matrix_ready, n_matrix_ready;
    logic [NZ_CW-1:0]      r_nz_count, n_nz_count;
    logic [DIM_W-1:0]      r_row, n_row;
    logic [NZ_CW-1:0]      r_j, n_j;
    logic [NZ_CW-1:0]      r_hi, n_hi;
    logic                  r_out_valid, n_out_valid;
    csr_smv_pkg::t_result  r_out, n_out;
    logic                  r_pend_valid, n_pend_valid;
    csr_smv_pkg::t_result  r_pend, n_pend;

    // datapath signals
    logic [CFG_W-1:0]      rows_c;
    logic [CFG_W-1:0]      cols_c;
    logic                  cfg_wr;
    logic                  acc_in;
    logic                  acc_mat;
    logic                  acc_vec;
    logic                  wrap;
    logic [DIM_W-1:0]      eff_row;
    logic [DIM_W-1:0]      eff_col;
    logic                  first_elem;
    logic [NZ_CW-1:0]      nzc;
    logic                  is_nz;
    logic [NZ_CW-1:0]      nzc_nx;
    logic [DIM_CW-1:0]     col_nx;
    logic [DIM_CW-1:0]     row_nx;
    logic                  row_done;
    logic                  mat_done;
    logic [CFG_W-1:0]      vec_nx;
    logic                  vec_ok;
    logic                  out_free;
    logic                  row_last;
    csr_smv_pkg::t_result  res_entry;
    csr_smv_pkg::t_result  res_rptr;
    csr_smv_pkg::t_result  res_err;
    csr_smv_pkg::t_result  res_prod;

    // memory and pipe connections
    logic                  nz_we;
    logic [NZ_AW-1:0]      nz_rd_addr;
    logic [DIM_W-1:0]      nz_rd_col;
    logic [VAL_W-1:0]      nz_rd_val;
    logic [DIM_W-1:0]      rm_wr_addr;
    logic                  rm_we_ptr;
    logic                  rm_we_vec;
    logic [DIM_W-1:0]      rm_rd_addr;
    logic [NZ_CW-1:0]      rm_rd_ptr;
    logic [VAL_W-1:0]      rm_rd_vec;
    csr_smv_pkg::t_mac_ctl mac_ctl;
    logic                  mac_busy;
    logic [VAL_W-1:0]      mac_acc;

    // effective dimensions
    assign rows_c = csr_smv_pkg::clamp_dim(r_num_rows);
    assign cols_c = csr_smv_pkg::clamp_dim(r_num_cols);

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == csr_smv_pkg::REG_NUM_COLS) ?
                    {{(32-CFG_W){1'b0}}, r_num_cols} : {{(32-CFG_W){1'b0}}, r_num_rows};

    // input handshake
    assign s_axis_tready = (r_state == csr_smv_pkg::ST_LOAD) && !r_pend_valid &&
                           (!r_out_valid || m_axis_tready);
    assign acc_in  = s_axis_tvalid && s_axis_tready;
    assign acc_mat = acc_in && !s_axis_tuser[0];
    assign acc_vec = acc_in && s_axis_tuser[0];
    assign out_free = !r_out_valid || m_axis_tready;

    // matrix element position and compression
    assign wrap = ({1'b0, r_cur_row} >= rows_c) || ({1'b0, r_cur_col} >= cols_c);
    assign eff_row = wrap ? '0 : r_cur_row;
    assign eff_col = wrap ? '0 : r_cur_col;
    assign first_elem = (eff_row == '0) && (eff_col == '0);
    assign nzc = first_elem ? '0 : r_nz_count;
    assign is_nz = (s_axis_tdata != '0) && (nzc < NZ_CW'(csr_smv_pkg::MAX_NZ));
    assign nzc_nx = nzc + NZ_CW'(is_nz);
    assign col_nx = {1'b0, eff_col} + DIM_CW'(1);
    assign row_nx = {1'b0, eff_row} + DIM_CW'(1);
    assign row_done = col_nx >= cols_c;
    assign mat_done = row_done && (row_nx >= rows_c);

    // vector length check
    assign vec_nx = (r_vec_count < csr_smv_pkg::VEC_SAT) ? r_vec_count + CFG_W'(1) : r_vec_count;
    assign vec_ok = r_matrix_ready && (vec_nx == cols_c);

    // candidate results
    assign row_last = ({1'b0, r_row} + DIM_CW'(1)) == rows_c;
    always_comb begin
        res_entry.kind     = csr_smv_pkg::KIND_ENTRY;
        res_entry.index    = eff_col;
        res_entry.position = nzc;
        res_entry.value    = s_axis_tdata;
        res_entry.last     = !row_done;

        res_rptr.kind      = csr_smv_pkg::KIND_RPTR;
        res_rptr.index     = eff_row;
        res_rptr.position  = nzc_nx;
        res_rptr.value     = '0;
        res_rptr.last      = 1'b1;

        res_err.kind       = csr_smv_pkg::KIND_ERR;
        res_err.index      = '0;
        res_err.position   = '0;
        res_err.value      = '0;
        res_err.last       = 1'b1;

        res_prod.kind      = csr_smv_pkg::KIND_PROD;
        res_prod.index     = r_row;
        res_prod.position  = '0;
        res_prod.value     = mac_acc;
        res_prod.last      = row_last;
    end

    // store writes during load
    assign nz_we      = acc_mat && is_nz;
    assign rm_we_ptr  = acc_mat && row_done;
    assign rm_we_vec  = acc_vec && (r_vec_count < CFG_W'(csr_smv_pkg::MAX_DIM));
    assign rm_wr_addr = acc_mat ? eff_row : r_vec_count[DIM_W-1:0];

    // store reads during the multiply
    assign mac_ctl.issue = (r_state == csr_smv_pkg::ST_WALK) && (r_j < r_hi);
    assign mac_ctl.clear = (r_state == csr_smv_pkg::ST_PTR);
    assign nz_rd_addr    = r_j[NZ_AW-1:0];
    assign rm_rd_addr    = (r_state == csr_smv_pkg::ST_PTR) ? r_row : nz_rd_col;

    csr_smv_nz_mem u_nz_mem (
        .i_clk     (i_clk),
        .i_we      (nz_we),
        .i_wr_addr (nzc[NZ_AW-1:0]),
        .i_wr_col  (eff_col),
        .i_wr_val  (s_axis_tdata),
        .i_rd_addr (nz_rd_addr),
        .o_rd_col  (nz_rd_col),
        .o_rd_val  (nz_rd_val)
    );

    csr_smv_row_mem u_row_mem (
        .i_clk     (i_clk),
        .i_wr_addr (rm_wr_addr),
        .i_we_ptr  (rm_we_ptr),
        .i_wr_ptr  (nzc_nx),
        .i_we_vec  (rm_we_vec),
        .i_wr_vec  (s_axis_tdata),
        .i_rd_addr (rm_rd_addr),
        .o_rd_ptr  (rm_rd_ptr),
        .o_rd_vec  (rm_rd_vec)
    );

    csr_smv_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_nz_val  (nz_rd_val),
        .i_vec_val (rm_rd_vec),
        .o_busy    (mac_busy),
        .o_acc     (mac_acc)
    );

    // next state, counters and output stage
    always_comb begin
        n_state        = r_state;
        n_num_rows     = r_num_rows;
        n_num_cols     = r_num_cols;
        n_cur_row      = r_cur_row;
        n_cur_col      = r_cur_col;
        n_vec_count    = r_vec_count;
        n_matrix_ready = r_matrix_ready;
        n_nz_count     = r_nz_count;
        n_row          = r_row;
        n_j            = r_j;
        n_hi           = r_hi;
        n_out          = r_out;
        n_out_valid    = r_out_valid && !m_axis_tready;
        n_pend         = r_pend;
        n_pend_valid   = r_pend_valid;

        // second result of a matrix element moves up once the first is taken
        if (r_out_valid && m_axis_tready && r_pend_valid) begin
            n_out        = r_pend;
            n_out_valid  = 1'b1;
            n_pend_valid = 1'b0;
        end

        unique case (r_state)
            csr_smv_pkg::ST_LOAD: begin
                if (acc_mat) begin
                    n_nz_count = nzc_nx;
                    if (first_elem) begin
                        n_matrix_ready = 1'b0;
                    end
                    if (row_done) begin
                        n_cur_col = '0;
                        n_cur_row = row_nx[DIM_W-1:0];
                        if (mat_done) begin
                            n_cur_row      = '0;
                            n_matrix_ready = 1'b1;
                        end
                    end else begin
                        n_cur_col = col_nx[DIM_W-1:0];
                        n_cur_row = eff_row;
                    end
                    if (is_nz) begin
                        n_out       = res_entry;
                        n_out_valid = 1'b1;
                        if (row_done) begin
                            n_pend       = res_rptr;
                            n_pend_valid = 1'b1;
                        end
                    end else if (row_done) begin
                        n_out       = res_rptr;
                        n_out_valid = 1'b1;
                    end
                end else if (acc_vec) begin
                    n_vec_count = vec_nx;
                    if (s_axis_tlast) begin
                        n_vec_count = '0;
                        if (vec_ok) begin
                            n_state = csr_smv_pkg::ST_PTR;
                            n_row   = '0;
                            n_j     = '0;
                        end else begin
                            n_out       = res_err;
                            n_out_valid = 1'b1;
                        end
                    end
                end
            end
            csr_smv_pkg::ST_PTR: begin
                n_state = csr_smv_pkg::ST_PTR_WAIT;
            end
            csr_smv_pkg::ST_PTR_WAIT: begin
                n_hi    = rm_rd_ptr;
                n_state = csr_smv_pkg::ST_WALK;
            end
            csr_smv_pkg::ST_WALK: begin
                if (mac_ctl.issue) begin
                    n_j = r_j + NZ_CW'(1);
                end else begin
                    n_state = csr_smv_pkg::ST_DRAIN;
                end
            end
            csr_smv_pkg::ST_DRAIN: begin
                if (!mac_busy) begin
                    n_state = csr_smv_pkg::ST_EMIT;
                end
            end
            csr_smv_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out       = res_prod;
                    n_out_valid = 1'b1;
                    if (row_last) begin
                        n_state = csr_smv_pkg::ST_LOAD;
                    end else begin
                        n_row   = r_row + DIM_W'(1);
                        n_state = csr_smv_pkg::ST_PTR;
                    end
                end
            end
            default: begin
                n_state = csr_smv_pkg::ST_LOAD;
            end
        endcase

        // register write restarts the matrix load
        if (cfg_wr) begin
            unique case (paddr[2])
                csr_smv_pkg::REG_NUM_ROWS: n_num_rows = pwdata[CFG_W-1:0];
                csr_smv_pkg::REG_NUM_COLS: n_num_cols = pwdata[CFG_W-1:0];
                default: n_num_rows = r_num_rows;
            endcase
            n_cur_row      = '0;
            n_cur_col      = '0;
            n_vec_count    = '0;
            n_matrix_ready = 1'b0;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csr_smv_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows     <= CFG_W'(csr_smv_pkg::MAX_DIM);
            r_num_cols     <= CFG_W'(csr_smv_pkg::MAX_DIM);
            r_cur_row      <= '0;
            r_cur_col      <= '0;
            r_vec_count    <= '0;
            r_matrix_ready <= 1'b0;
            r_nz_count     <= '0;
            r_row          <= '0;
            r_j            <= '0;
            r_hi           <= '0;
            r_out_valid    <= 1'b0;
            r_pend_valid   <= 1'b0;
        end else begin
            r_num_rows     <= n_num_rows;
            r_num_cols     <= n_num_cols;
            r_cur_row      <= n_cur_row;
            r_cur_col      <= n_cur_col;
            r_vec_count    <= n_vec_count;
            r_matrix_ready <= n_matrix_ready;
            r_nz_count     <= n_nz_count;
            r_row          <= n_row;
            r_j            <= n_j;
            r_hi           <= n_hi;
            r_out_valid    <= n_out_valid;
            r_pend_valid   <= n_pend_valid;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    // result stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{csr_smv_pkg::PAD_W{1'b0}}, r_out.value, r_out.position,
                            r_out.index};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

    // checks on the sequencer and output stage
    `CSR_SMV_ASSERT_IMP(a_pend_behind_out, i_clk, i_rst_n, r_pend_valid, r_out_valid)
    `CSR_SMV_ASSERT_IMP(a_walk_in_row, i_clk, i_rst_n, r_state == csr_smv_pkg::ST_WALK, r_j <= r_hi)
    `CSR_SMV_ASSERT_IMP(a_emit_drained, i_clk, i_rst_n, r_state == csr_smv_pkg::ST_EMIT, !mac_busy)
    `CSR_SMV_ASSERT_IMP(a_mult_ready, i_clk, i_rst_n, r_state == csr_smv_pkg::ST_PTR, r_matrix_ready && !r_pend_valid)
    `CSR_SMV_ASSERT_ALWAYS(a_nz_bound, i_clk, i_rst_n, r_nz_count <= NZ_CW'(csr_smv_pkg::MAX_NZ))

endmodule
